// ----- src/sbfd_pkg.sv -----
package sbfd_pkg;

  localparam int FRAME_BYTES = 25;
  localparam int CHANNELS    = 16;
  localparam int RAW_W       = 11;
  localparam int CH_BITS     = CHANNELS * RAW_W;
  // bytes 1..23 of a frame: channel data plus the flag byte
  localparam int KEEP_BITS   = 8 * (FRAME_BYTES - 2);
  localparam int ASM_BITS    = 8 * (FRAME_BYTES - 2);
  localparam int QDEPTH      = 2;

  localparam logic [4:0] LAST_POS    = 5'(FRAME_BYTES - 1);
  localparam logic [7:0] HEADER_BYTE = 8'h0F;
  localparam logic [7:0] END_BYTE    = 8'h00;
  localparam logic [3:0] LAST_CH     = 4'(CHANNELS - 1);

  typedef enum logic [1:0] {
    CMD_BYTE = 2'd0,
    CMD_GAP  = 2'd1,
    CMD_TICK = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_RAW_LOW   = 3'd0,
    REG_RAW_HIGH  = 3'd1,
    REG_OUT_LOW   = 3'd2,
    REG_OUT_HIGH  = 3'd3,
    REG_WINDOW    = 3'd4,
    REG_MIN_GOOD  = 3'd5,
    REG_FS_MASK   = 3'd6,
    REG_UNUSED    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         channel_index;
    logic signed [15:0] channel_value;
    logic               failsafe;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [10:0]        raw_low;
    logic [10:0]        raw_high;
    logic signed [15:0] out_low;
    logic signed [15:0] out_high;
    logic [7:0]         window_ticks;
    logic [7:0]         min_good_frames;
    logic [7:0]         failsafe_mask;
  } cfg_t;

  typedef struct packed {
    logic               fs;
    logic [CH_BITS-1:0] raw;
  } job_t;

endpackage

// ----- src/sbfd_front.sv -----
module sbfd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  sbfd_pkg::cfg_t    cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  sbfd_pkg::in_item_t in_data,
  output logic              push,
  output sbfd_pkg::job_t    push_job,
  input  logic              q_full
);
  import sbfd_pkg::*;

  logic [ASM_BITS-1:0]  asm_r;
  logic [KEEP_BITS-1:0] committed_r;
  logic [4:0]           pos_r;
  logic                 in_frame_r;
  logic [7:0]           good_r;
  logic [7:0]           tick_r;
  logic [7:0]           tick_nxt;
  logic                 take;
  logic                 win_end;
  logic                 flag_fs;

  assign in_stall = (in_data.command == CMD_TICK) && q_full;
  assign take     = in_valid && !in_stall;
  assign push     = take && (in_data.command == CMD_TICK);
  assign tick_nxt = tick_r + 8'd1;
  assign win_end  = (tick_nxt == cfg.window_ticks);
  assign flag_fs  = (committed_r[KEEP_BITS-1 -: 8] & cfg.failsafe_mask) != 8'd0;

  assign push_job.fs  = flag_fs || (win_end && (good_r < cfg.min_good_frames));
  assign push_job.raw = committed_r[CH_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      committed_r <= '0;
      pos_r       <= '0;
      in_frame_r  <= 1'b0;
      good_r      <= '0;
      tick_r      <= '0;
    end else if (take) begin
      unique case (in_data.command)
        CMD_BYTE: begin
          if (!in_frame_r) begin
            if (in_data.rx_byte == HEADER_BYTE) begin
              pos_r      <= 5'd1;
              in_frame_r <= 1'b1;
            end
          end else if (pos_r == LAST_POS) begin
            pos_r      <= '0;
            in_frame_r <= 1'b0;
            if (in_data.rx_byte == END_BYTE) begin
              committed_r <= asm_r;
              if (good_r != 8'hFF) good_r <= good_r + 8'd1;
            end
          end else begin
            pos_r <= pos_r + 5'd1;
          end
        end
        CMD_GAP: in_frame_r <= 1'b0;
        CMD_TICK: begin
          if (win_end) begin
            tick_r <= '0;
            good_r <= '0;
          end else begin
            tick_r <= tick_nxt;
          end
        end
        default: ;
      endcase
    end
  end

  // frame bytes shift in from the top; once the flag byte is in, bytes 1..23
  // sit low to high and the header has dropped out the bottom
  always_ff @(posedge clk) begin
    if (take && in_data.command == CMD_BYTE &&
        (in_frame_r || in_data.rx_byte == HEADER_BYTE)) begin
      asm_r <= {in_data.rx_byte, asm_r[ASM_BITS-1:8]};
    end
  end

endmodule

// ----- src/sbfd_queue.sv -----
module sbfd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  sbfd_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output sbfd_pkg::job_t pop_job
);
  import sbfd_pkg::*;

  job_t       mem_r [QDEPTH];
  logic       wr_r;
  logic       rd_r;
  logic [1:0] cnt_r;

  assign full    = (cnt_r == 2'(QDEPTH));
  assign empty   = (cnt_r == 2'd0);
  assign pop_job = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= ~wr_r;
      if (pop)  rd_r <= ~rd_r;
      if (push && !pop) cnt_r <= cnt_r + 2'd1;
      else if (pop && !push) cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_job;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'(QDEPTH))
    else $error("queue count out of range");
`endif

endmodule

// ----- src/sbfd_back.sv -----
module sbfd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  sbfd_pkg::cfg_t      cfg,
  input  logic                q_empty,
  input  sbfd_pkg::job_t      q_job,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output sbfd_pkg::out_item_t out_data
);
  import sbfd_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_DIV  = 5'b00100,
    S_FIN  = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t              st_r;
  logic [CH_BITS-1:0]  bits_r;
  logic [3:0]          ch_r;
  logic signed [28:0]  prod_r;
  logic                neg_r;
  logic [10:0]         dmag_r;
  logic [10:0]         rem_r;
  logic [28:0]         quo_r;
  logic [4:0]          cnt_r;
  out_item_t           res_r;

  logic signed [11:0]  dnum;
  logic signed [16:0]  drng;
  logic signed [11:0]  den;
  logic [28:0]         pmag;
  logic [11:0]         rshift;
  logic [12:0]         rdiff;
  logic signed [29:0]  quo_s;
  logic signed [30:0]  val;
  logic signed [15:0]  val_sat;
  logic                emit_done;

  assign dnum  = $signed({1'b0, bits_r[RAW_W-1:0]}) - $signed({1'b0, cfg.raw_low});
  assign drng  = 17'(cfg.out_high) - 17'(cfg.out_low);
  assign den   = $signed({1'b0, cfg.raw_high}) - $signed({1'b0, cfg.raw_low});
  assign pmag  = prod_r[28] ? 29'(-prod_r) : 29'(prod_r);

  assign rshift = {rem_r, quo_r[28]};
  assign rdiff  = {1'b0, rshift} - {2'b0, dmag_r};

  assign quo_s = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
  assign val   = 31'(quo_s) + 31'(cfg.out_low);
  always_comb begin
    priority if (val > 31'sd32767)  val_sat = 16'sh7FFF;
    else if (val < -31'sd32768)     val_sat = 16'sh8000;
    else                            val_sat = val[15:0];
  end

  assign pop       = (st_r == S_IDLE) && !q_empty;
  assign out_valid = (st_r == S_EMIT);
  assign out_data  = res_r;
  assign emit_done = res_r.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      unique case (st_r)
        S_IDLE: if (!q_empty) st_r <= q_job.fs ? S_EMIT : S_MUL;
        S_MUL:  st_r <= (den == 12'sd0) ? S_FIN : S_DIV;
        S_DIV:  if (cnt_r == 5'd0) st_r <= S_FIN;
        S_FIN:  st_r <= S_EMIT;
        S_EMIT: if (!out_stall) st_r <= emit_done ? S_IDLE : S_MUL;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      S_IDLE: begin
        bits_r <= q_job.raw;
        ch_r   <= '0;
        res_r  <= '{channel_index: 4'd0, channel_value: 16'sd0, failsafe: 1'b1, last: 1'b1};
      end
      S_MUL: begin
        prod_r <= 29'(dnum) * 29'(drng);
        neg_r  <= dnum[11] ^ drng[16] ^ den[11];
        dmag_r <= den[11] ? 11'(-den) : 11'(den);
        quo_r  <= '0;
        rem_r  <= '0;
        cnt_r  <= 5'd29;
      end
      S_DIV: begin
        // load the dividend on the first step, then one quotient bit a cycle
        if (cnt_r == 5'd29) begin
          quo_r <= (prod_r == 29'sd0 || (dnum == 12'sd0) || (drng == 17'sd0)) ? '0 : pmag;
          neg_r <= neg_r && (prod_r != 29'sd0);
        end else if (!rdiff[12]) begin
          rem_r <= rdiff[10:0];
          quo_r <= {quo_r[27:0], 1'b1};
        end else begin
          rem_r <= rshift[10:0];
          quo_r <= {quo_r[27:0], 1'b0};
        end
        cnt_r <= cnt_r - 5'd1;
      end
      S_FIN: begin
        res_r <= '{channel_index: ch_r, channel_value: val_sat, failsafe: 1'b0,
                   last: (ch_r == LAST_CH)};
      end
      S_EMIT: begin
        if (!out_stall) begin
          ch_r   <= ch_r + 4'd1;
          bits_r <= bits_r >> RAW_W;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_fs_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.failsafe |-> out_data.last && out_data.channel_value == 16'sd0)
    else $error("failsafe result malformed");
  a_last_ch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.failsafe |-> out_data.last == (out_data.channel_index == LAST_CH))
    else $error("last flag out of step with channel index");
  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");
`endif

endmodule

// ----- src/sbus_frame_decoder.sv -----
// SBUS frame decoder. Each input transfer carries a received byte, a gap
// timeout or a 10 ms tick. Bytes and timeouts are taken every cycle; a tick is
// held off only while two earlier ticks are still queued for decoding. A
// tick yields either one failsafe result or sixteen mapped channel values;
// each channel passes through the back end as one multiply, a dividend
// load and a 29-step restoring divider (skipped when raw_high equals
// raw_low), saturation and the result state, while a failsafe tick goes
// straight to its result. Configuration writes are taken at once.
module sbus_frame_decoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sbfd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sbfd_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_addr,
  input  logic [15:0]         cfg_wdata
);
  import sbfd_pkg::*;

  cfg_t cfg_r;
  logic push, pop, q_full, q_empty;
  job_t push_job, pop_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{raw_low: 11'd172, raw_high: 11'd1811, out_low: 16'sd1000,
                 out_high: 16'sd2000, window_ticks: 8'd100, min_good_frames: 8'd5,
                 failsafe_mask: 8'd8};
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_RAW_LOW:  cfg_r.raw_low         <= cfg_wdata[10:0];
        REG_RAW_HIGH: cfg_r.raw_high        <= cfg_wdata[10:0];
        REG_OUT_LOW:  cfg_r.out_low         <= cfg_wdata;
        REG_OUT_HIGH: cfg_r.out_high        <= cfg_wdata;
        REG_WINDOW:   cfg_r.window_ticks    <= cfg_wdata[7:0];
        REG_MIN_GOOD: cfg_r.min_good_frames <= cfg_wdata[7:0];
        REG_FS_MASK:  cfg_r.failsafe_mask   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  sbfd_front u_front (
    .clk, .rst_n, .cfg(cfg_r), .in_valid, .in_stall, .in_data,
    .push, .push_job, .q_full
  );

  sbfd_queue u_queue (
    .clk, .rst_n, .push, .push_job, .full(q_full), .pop, .empty(q_empty),
    .pop_job
  );

  sbfd_back u_back (
    .clk, .rst_n, .cfg(cfg_r), .q_empty, .q_job(pop_job), .pop,
    .out_valid, .out_stall, .out_data
  );

endmodule
